// ===== src/cfb_pkg.sv =====
// ----------------------------------------------------------------------------
// cfb_pkg
// Shared types, constants and the CRC-16 byte update of the framer.
// ----------------------------------------------------------------------------
package cfb_pkg;

    typedef logic [7:0]  t_byte;
    typedef logic [15:0] t_crc;
    typedef logic [1:0]  t_cfg_idx;

    // register indexes of the configuration channel
    localparam t_cfg_idx CFG_START  = 2'd0;
    localparam t_cfg_idx CFG_END    = 2'd1;
    localparam t_cfg_idx CFG_ESCAPE = 2'd2;

    localparam t_byte RST_START  = 8'd1;
    localparam t_byte RST_END    = 8'd4;
    localparam t_byte RST_ESCAPE = 8'd27;

    localparam t_crc CRC_INIT = 16'hFFFF;
    localparam t_crc CRC_POLY = 16'hA001;

    // longest expansion of one input beat
    localparam int unsigned MAX_SEQ = 8;

    // reflected crc-16, one byte, eight shift steps
    function automatic t_crc crc_update(input t_crc crc, input t_byte b);
        t_crc c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

    function automatic logic is_special(input t_byte b, input t_byte s,
                                        input t_byte e, input t_byte x);
        return (b == s) || (b == e) || (b == x);
    endfunction

endpackage

// ===== src/cfb_intf.sv =====
// ----------------------------------------------------------------------------
// cfb_intf
// Handshake channels of the framer: payload in, line bytes out, register writes.
// ----------------------------------------------------------------------------
interface cfb_in_if;
    import cfb_pkg::*;
    logic  valid;
    logic  ready;
    t_byte data_byte;
    logic  last_byte;
    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface cfb_out_if;
    import cfb_pkg::*;
    logic  valid;
    logic  ready;
    t_byte line_byte;
    logic  frame_end;
    logic  run_last;
    modport source (output valid, output line_byte, output frame_end, output run_last,
                    input ready);
    modport sink   (input valid, input line_byte, input frame_end, input run_last,
                    output ready);
endinterface

interface cfb_cfg_if;
    import cfb_pkg::*;
    logic     valid;
    logic     ready;
    t_cfg_idx index;
    t_byte    data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== src/crc16_byte_stuffing_framer_unit.sv =====
// ----------------------------------------------------------------------------
// crc16_byte_stuffing_framer_unit
// Byte-stuffing frame transmitter with a reflected CRC-16 trailer.
// ----------------------------------------------------------------------------
// i_in carries payload bytes, last_byte set on the final byte of a frame.
// o_out carries line bytes: start byte before the first payload byte, each
// payload and crc byte preceded by the escape byte when it matches start,
// end or escape, then crc high, crc low and the end byte (frame_end set).
// run_last marks the final line byte caused by one input beat.
// i_cfg writes start (0), end (1) and escape (2); other indexes are dropped.
// An accepted beat sits in an input register, is expanded in one pass into
// a result shift buffer of up to eight bytes once that buffer is empty or
// sends its last byte, and its first line byte shows once it is loaded.
// The buffer sends one byte per cycle while the receiver is ready; a beat
// yields 1 to 8 line bytes. The next beat is taken while results drain and
// is loaded on the cycle the last byte of the previous one leaves. When the
// receiver stalls the buffer holds and the input register fills, then
// i_in.ready drops.
// Reset restores the default special bytes, closes any frame and sets
// the crc to 0xFFFF; the block is ready in the cycle after reset.
// ----------------------------------------------------------------------------
module crc16_byte_stuffing_framer_unit
    import cfb_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    cfb_in_if.sink    i_in,
    cfb_out_if.source o_out,
    cfb_cfg_if.sink   i_cfg
);

    t_byte r_start;
    t_byte r_end;
    t_byte r_escape;

    logic  r_in_valid;
    t_byte r_in_data;
    logic  r_in_last;

    t_crc  r_crc;
    logic  r_in_frame;

    t_byte      r_buf [MAX_SEQ];
    logic [3:0] r_cnt;
    logic       r_close;

    t_byte      s_seq [MAX_SEQ];
    logic [3:0] s_len;
    t_crc       s_crc_base;
    t_crc       n_crc;

    logic s_out_fire;
    logic s_load;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start  <= RST_START;
            r_end    <= RST_END;
            r_escape <= RST_ESCAPE;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                CFG_START:  r_start  <= i_cfg.data;
                CFG_END:    r_end    <= i_cfg.data;
                CFG_ESCAPE: r_escape <= i_cfg.data;
                default: ;
            endcase
        end
    end

    assign s_out_fire  = o_out.valid && o_out.ready;
    assign s_load      = r_in_valid && ((r_cnt == 4'd0) || (s_out_fire && r_cnt == 4'd1));
    assign i_in.ready  = !r_in_valid || s_load;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in_data <= i_in.data_byte;
            r_in_last <= i_in.last_byte;
        end
    end

    // expansion of one beat into its line bytes
    always_comb begin
        s_len = '0;
        for (int i = 0; i < MAX_SEQ; i++) begin
            s_seq[i] = '0;
        end
        s_crc_base = r_in_frame ? r_crc : CRC_INIT;
        n_crc      = crc_update(s_crc_base, r_in_data);

        if (!r_in_frame) begin
            s_seq[s_len[2:0]] = r_start;
            s_len = s_len + 4'd1;
        end
        if (is_special(r_in_data, r_start, r_end, r_escape)) begin
            s_seq[s_len[2:0]] = r_escape;
            s_len = s_len + 4'd1;
        end
        s_seq[s_len[2:0]] = r_in_data;
        s_len = s_len + 4'd1;

        if (r_in_last) begin
            if (is_special(n_crc[15:8], r_start, r_end, r_escape)) begin
                s_seq[s_len[2:0]] = r_escape;
                s_len = s_len + 4'd1;
            end
            s_seq[s_len[2:0]] = n_crc[15:8];
            s_len = s_len + 4'd1;
            if (is_special(n_crc[7:0], r_start, r_end, r_escape)) begin
                s_seq[s_len[2:0]] = r_escape;
                s_len = s_len + 4'd1;
            end
            s_seq[s_len[2:0]] = n_crc[7:0];
            s_len = s_len + 4'd1;
            s_seq[s_len[2:0]] = r_end;
            s_len = s_len + 4'd1;
        end
    end

    // frame state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc      <= CRC_INIT;
            r_in_frame <= 1'b0;
        end else if (s_load) begin
            r_crc      <= r_in_last ? CRC_INIT : n_crc;
            r_in_frame <= !r_in_last;
        end
    end

    // result shift buffer, head byte is on the line
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (s_load) begin
            r_cnt <= s_len;
        end else if (s_out_fire) begin
            r_cnt <= r_cnt - 4'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_load) begin
            r_buf   <= s_seq;
            r_close <= r_in_last;
        end else if (s_out_fire) begin
            for (int i = 0; i < MAX_SEQ - 1; i++) begin
                r_buf[i] <= r_buf[i+1];
            end
        end
    end

    assign o_out.valid     = (r_cnt != 4'd0);
    assign o_out.line_byte = r_buf[0];
    assign o_out.run_last  = (r_cnt == 4'd1);
    assign o_out.frame_end = r_close && (r_cnt == 4'd1);

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= 4'd8)
        else $error("result count out of range");

    a_load_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_load |=> (r_cnt != 4'd0))
        else $error("loaded beat yields no line bytes");

    a_close_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_load && r_in_last) |=> (!r_in_frame && r_crc == CRC_INIT))
        else $error("frame not closed after last byte");

    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt > 4'd1 && r_in_valid) |-> !s_load)
        else $error("buffer reloaded while results remain");

    a_hold_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.ready) |=> ($stable(r_cnt) && $stable(r_buf[0])))
        else $error("line byte changed under stall");

endmodule
